### rtl/core/tcw_pkg.sv
// Package for the text console writer: item types, codes, sizes and helpers.
`default_nettype none

package tcw_pkg;

  localparam int unsigned MAX_COLS        = 80;
  localparam int unsigned MAX_ROWS        = 25;
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_PUT_CHAR   = 2'd0;
  localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
  localparam logic [1:0] CMD_CLEAR      = 2'd2;
  localparam logic [1:0] CMD_READ_CELL  = 2'd3;

  localparam logic [1:0] CFG_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_ATTRIBUTE = 2'd2;

  localparam logic [6:0] RESET_WIDTH     = 7'd80;
  localparam logic [6:0] RESET_HEIGHT    = 7'd25;
  localparam logic [7:0] RESET_ATTRIBUTE = 8'd7;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd127;

  localparam int unsigned CELL_W = 16;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_CR     = 3'd1,
    OP_LF     = 3'd2,
    OP_PRINT  = 3'd3,
    OP_SETCUR = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_READ   = 3'd6
  } op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [4:0] row_index;
    logic [6:0] col_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        cursor_row;
    logic [6:0]        cursor_col;
    logic [CELL_W-1:0] cell_value;
    logic              did_scroll;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [4:0] row_index;
    logic [6:0] col_index;
  } cmd_item_t;

  typedef struct packed {
    logic [6:0] width;
    logic [4:0] height;
    logic [7:0] attribute;
  } cfg_t;

  // limit a screen dimension to 1..maxv
  function automatic logic [6:0] clamp_dim(logic [6:0] v, int unsigned maxv);
    if (v == 7'd0) return 7'd1;
    if (32'(v) > maxv) return 7'(maxv);
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/text_console_writer_top.sv
// Top level of the text console writer: configuration registers, front and back ends.
//
// Usage: command items enter through push/full and results leave through empty/pop,
// one result per command, in order. Configuration (width, height, attribute) is written
// through cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i; cfg_ready_o is always high.
// Path: a command passes the command queue and then the result register; read cell
// also passes the registered buffer read and a pending cell register.
// Throughput: put char without scroll, set cursor and out of range reads are done in
// the idle state; read cell, scroll and clear pass through further states, and the
// back end takes no new command until it is idle again. Scroll and clear are bounded
// by the single write port of the buffer, one cell per cycle.
// Reset: the buffer is zeroed by a pass over all MaxCols*MaxRows cells, during which
// full stays high; configuration writes are taken as ever.
// Stalls: a waiting result is held while pop is low; the back end stops at its next
// result and the two-entry command queue fills, then full rises.
`default_nettype none

module text_console_writer_top #(
  parameter int unsigned MaxCols = tcw_pkg::MAX_COLS,
  parameter int unsigned MaxRows = tcw_pkg::MAX_ROWS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire tcw_pkg::in_item_t   in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output tcw_pkg::out_item_t       out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i
);
  import tcw_pkg::*;

  cfg_t      cfg_q;
  logic      cmd_valid, cmd_ready, init_busy, res_valid;
  cmd_item_t cmd;

  assign cfg_ready_o = 1'b1;

  // sizes are stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= clamp_dim(RESET_WIDTH, MaxCols);
      cfg_q.height    <= 5'(clamp_dim(RESET_HEIGHT, MaxRows));
      cfg_q.attribute <= RESET_ATTRIBUTE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDTH:     cfg_q.width     <= clamp_dim(cfg_data_i[6:0], MaxCols);
        CFG_HEIGHT:    cfg_q.height    <= 5'(clamp_dim({2'b00, cfg_data_i[4:0]}, MaxRows));
        CFG_ATTRIBUTE: cfg_q.attribute <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_item_i),
    .push       (push),
    .full       (full),
    .init_busy_i(init_busy),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_ready_i(cmd_ready)
  );

  tcw_back #(
    .MaxCols(MaxCols),
    .MaxRows(MaxRows)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .init_busy_o(init_busy),
    .res_o      (out_item_o),
    .res_valid_o(res_valid),
    .res_pop_i  (pop)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

### rtl/core/tcw_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/tcw_front.sv
// Front end: takes command items, classifies them and queues them for the back end.
`default_nettype none

module tcw_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcw_pkg::in_item_t   item_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                init_busy_i,
  output logic                     cmd_valid_o,
  output tcw_pkg::cmd_item_t       cmd_o,
  input  wire logic                cmd_ready_i
);
  import tcw_pkg::*;

  localparam int unsigned Depth = CMD_QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_item_t       slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  cmd_item_t       classified;
  logic            do_push, do_pop;

  always_comb begin
    classified.char_code = item_i.char_code;
    classified.row_index = item_i.row_index;
    classified.col_index = item_i.col_index;
    case (item_i.cmd)
      CMD_PUT_CHAR: begin
        if (item_i.char_code == CHAR_CR) begin
          classified.op = OP_CR;
        end else if (item_i.char_code == CHAR_LF) begin
          classified.op = OP_LF;
        end else if (item_i.char_code inside {[CHAR_SPACE:CHAR_LAST]}) begin
          classified.op = OP_PRINT;
        end else begin
          classified.op = OP_NOP;
        end
      end
      CMD_SET_CURSOR: classified.op = OP_SETCUR;
      CMD_CLEAR:      classified.op = OP_CLEAR;
      default:        classified.op = OP_READ;
    endcase
  end

  assign full        = init_busy_i || (count_q == CntW'(Depth));
  assign do_push     = push && !full;
  assign cmd_valid_o = (count_q != '0);
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= classified;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcw_back.sv
// Back end: cursor, screen buffer, scroll and clear sequencing, result register.
`default_nettype none

module tcw_back #(
  parameter int unsigned MaxCols = tcw_pkg::MAX_COLS,
  parameter int unsigned MaxRows = tcw_pkg::MAX_ROWS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcw_pkg::cfg_t       cfg_i,
  input  wire logic                cmd_valid_i,
  input  wire tcw_pkg::cmd_item_t  cmd_i,
  output logic                     cmd_ready_o,
  output logic                     init_busy_o,
  output tcw_pkg::out_item_t       res_o,
  output logic                     res_valid_o,
  input  wire logic                res_pop_i
);
  import tcw_pkg::*;

  localparam int unsigned Cells = MaxCols * MaxRows;
  localparam int unsigned AddrW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CW    = (AddrW + 1 > 13) ? AddrW + 1 : 13;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_COPY = 6'b000100,
    S_FILL = 6'b001000,
    S_READ = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d, base_q, base_d, last_q, last_d;
  logic [4:0]        cur_row_q, cur_row_d;
  logic [6:0]        cur_col_q, cur_col_d;
  logic [CELL_W-1:0] pend_cell_q, pend_cell_d;
  logic              pend_scroll_q, pend_scroll_d;
  out_item_t         res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              ram_we;
  logic [CW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]     w_ext, h_ext, cur_addr, pos_addr, scroll_n;
  logic [CELL_W-1:0] blank;
  logic              pos_in, out_free, is_put, need_scroll;
  logic [5:0]        row_n;
  logic [6:0]        col_n;
  logic [7:0]        col_inc;
  logic              emit_now, emit_scroll;
  logic [CELL_W-1:0] emit_cell;

  assign w_ext    = CW'(cfg_i.width);
  assign h_ext    = CW'(cfg_i.height);
  assign blank    = {cfg_i.attribute, CHAR_SPACE};
  assign cur_addr = CW'(cur_row_q) * w_ext + CW'(cur_col_q);
  assign pos_addr = CW'(cmd_i.row_index) * w_ext + CW'(cmd_i.col_index);
  assign scroll_n = (h_ext - CW'(1)) * w_ext;
  assign pos_in   = (cmd_i.row_index < cfg_i.height) && (cmd_i.col_index < cfg_i.width);
  assign out_free = !res_valid_q || res_pop_i;
  assign is_put   = cmd_i.op inside {OP_NOP, OP_CR, OP_LF, OP_PRINT};

  // cursor step of a put char command
  always_comb begin
    row_n   = {1'b0, cur_row_q};
    col_n   = cur_col_q;
    col_inc = {1'b0, cur_col_q} + 8'd1;
    case (cmd_i.op)
      OP_CR: col_n = '0;
      OP_LF: begin
        col_n = '0;
        row_n = row_n + 6'd1;
      end
      OP_PRINT: begin
        if (col_inc >= {1'b0, cfg_i.width}) begin
          row_n = row_n + 6'd1;
          col_n = '0;
        end else begin
          col_n = col_inc[6:0];
        end
      end
      default: ;
    endcase
    need_scroll = is_put && (row_n >= {1'b0, cfg_i.height});
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    base_d        = base_q;
    last_d        = last_q;
    cur_row_d     = cur_row_q;
    cur_col_d     = cur_col_q;
    pend_cell_d   = pend_cell_q;
    pend_scroll_d = pend_scroll_q;
    res_d         = res_q;
    res_valid_d   = res_valid_q && !res_pop_i;
    ram_we        = 1'b0;
    ram_waddr     = cnt_q;
    ram_wdata     = blank;
    ram_raddr     = pos_addr;
    cmd_ready_o   = 1'b0;
    emit_now      = 1'b0;
    emit_cell     = '0;
    emit_scroll   = 1'b0;

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (cnt_q == CW'(Cells - 1)) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o   = 1'b1;
          pend_cell_d   = '0;
          pend_scroll_d = 1'b0;
          case (cmd_i.op)
            OP_SETCUR: begin
              if (pos_in) begin
                cur_row_d = cmd_i.row_index;
                cur_col_d = cmd_i.col_index;
              end
              emit_now = 1'b1;
            end
            OP_CLEAR: begin
              cur_row_d = '0;
              cur_col_d = '0;
              base_d    = '0;
              last_d    = scroll_n + w_ext - CW'(1);
              cnt_d     = '0;
              state_d   = S_FILL;
            end
            OP_READ: begin
              if (pos_in && (pos_addr < CW'(Cells))) begin
                state_d = S_READ;
              end else begin
                emit_now = 1'b1;
              end
            end
            default: begin
              if (cmd_i.op == OP_PRINT) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {cfg_i.attribute, cmd_i.char_code};
              end
              cur_col_d = col_n;
              if (need_scroll) begin
                cur_row_d     = cfg_i.height - 5'd1;
                pend_scroll_d = 1'b1;
                base_d        = scroll_n;
                cnt_d         = '0;
                if (scroll_n == '0) begin
                  last_d  = w_ext - CW'(1);
                  state_d = S_FILL;
                end else begin
                  state_d = S_COPY;
                end
              end else begin
                cur_row_d = row_n[4:0];
                emit_now  = 1'b1;
              end
            end
          endcase
        end
      end
      S_COPY: begin
        // read one row ahead, write the word read in the cycle before
        ram_raddr = cnt_q + w_ext;
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q - CW'(1);
          ram_wdata = ram_rdata;
        end
        if (cnt_q == base_q) begin
          cnt_d   = '0;
          last_d  = w_ext - CW'(1);
          state_d = S_FILL;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = base_q + cnt_q;
        if (cnt_q == last_q) begin
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_READ: begin
        pend_cell_d = ram_rdata;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit_now    = 1'b1;
          emit_cell   = pend_cell_q;
          emit_scroll = pend_scroll_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit_now) begin
      res_valid_d      = 1'b1;
      res_d.cursor_row = cur_row_d;
      res_d.cursor_col = cur_col_d;
      res_d.cell_value = emit_cell;
      res_d.did_scroll = emit_scroll;
    end
  end

  tcw_ram #(
    .Width(CELL_W),
    .Depth(Cells)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we && (ram_waddr < CW'(Cells))),
    .waddr_i(ram_waddr[AddrW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q        <= base_d;
    last_q        <= last_d;
    pend_cell_q   <= pend_cell_d;
    pend_scroll_q <= pend_scroll_d;
    res_q         <= res_d;
  end

  assign init_busy_o = (state_q == S_INIT);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == S_IDLE || state_q == S_EMIT))
    else $error("result loaded outside idle or emit");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) && res_q.did_scroll |-> res_q.cursor_row == cfg_i.height - 5'd1)
    else $error("scroll left cursor off the last row");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> cnt_q <= last_q)
    else $error("fill counter ran past its end");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT |-> !res_valid_q && !cmd_ready_o)
    else $error("activity during buffer initialisation");

endmodule

`default_nettype wire
